// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the stack controller and datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BSTK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bstk: property failed");

// Check that a condition never holds on a rising clock edge outside reset.
`define BSTK_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bstk: forbidden condition seen");

`endif

// ----- hdl/bstk_pkg.sv -----
// Types and constants shared by the bounded stack modules.
`default_nettype none

package bstk_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    typedef enum logic [3:0] {
        EM_NONE     = 4'd0,
        EM_PUSH_OK  = 4'd1,
        EM_FULL     = 4'd2,
        EM_EMPTY    = 4'd3,
        EM_POP      = 4'd4,
        EM_DUMP     = 4'd5,
        EM_FOUND    = 4'd6,
        EM_NOTFOUND = 4'd7,
        EM_QUERY    = 4'd8
    } emit_t;

    typedef struct packed {
        logic  push;
        logic  pop_commit;
        logic  key_load;
        logic  idx_load_top;
        logic  idx_load_bottom;
        logic  idx_dec;
        logic  idx_inc;
        emit_t emit;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic hit;
        logic idx_zero;
        logic idx_top;
    } sts_t;

endpackage

`default_nettype wire

// ----- hdl/bstk_ctrl.sv -----
// Controller state machine that sequences stack operations.
`default_nettype none

`include "assert_macros.svh"

module bstk_ctrl
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [bstk_pkg::OP_W-1:0]   operation,
    input  wire bstk_pkg::sts_t              sts,
    output bstk_pkg::cmd_t                   cmd,
    output logic                             busy
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RD   = 3'b010,
        ST_EV   = 3'b100
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [bstk_pkg::OP_W-1:0]   op_reg;
    logic [bstk_pkg::OP_W-1:0]   op_next;

    always_comb
    begin
        state_next          = state_reg;
        op_next             = op_reg;
        cmd.push            = 1'b0;
        cmd.pop_commit      = 1'b0;
        cmd.key_load        = 1'b0;
        cmd.idx_load_top    = 1'b0;
        cmd.idx_load_bottom = 1'b0;
        cmd.idx_dec         = 1'b0;
        cmd.idx_inc         = 1'b0;
        cmd.emit            = bstk_pkg::EM_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next = operation;
                    case (operation)
                        bstk_pkg::OP_PUSH:
                        begin
                            if (sts.full)
                            begin
                                cmd.emit = bstk_pkg::EM_FULL;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                                cmd.emit = bstk_pkg::EM_PUSH_OK;
                            end
                        end
                        bstk_pkg::OP_POP, bstk_pkg::OP_DUMP:
                        begin
                            if (sts.empty)
                            begin
                                cmd.emit = bstk_pkg::EM_EMPTY;
                            end
                            else
                            begin
                                cmd.idx_load_top = 1'b1;
                                state_next       = ST_RD;
                            end
                        end
                        bstk_pkg::OP_SEARCH:
                        begin
                            if (sts.empty)
                            begin
                                cmd.emit = bstk_pkg::EM_EMPTY;
                            end
                            else
                            begin
                                cmd.key_load        = 1'b1;
                                cmd.idx_load_bottom = 1'b1;
                                state_next          = ST_RD;
                            end
                        end
                        bstk_pkg::OP_QUERY:
                        begin
                            cmd.emit = bstk_pkg::EM_QUERY;
                        end
                        default:
                        begin
                            cmd.emit = bstk_pkg::EM_NONE;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                state_next = ST_EV;
            end
            ST_EV:
            begin
                state_next = ST_IDLE;
                case (op_reg)
                    bstk_pkg::OP_POP:
                    begin
                        cmd.pop_commit = 1'b1;
                        cmd.emit       = bstk_pkg::EM_POP;
                    end
                    bstk_pkg::OP_DUMP:
                    begin
                        cmd.emit = bstk_pkg::EM_DUMP;
                        if (!sts.idx_zero)
                        begin
                            cmd.idx_dec = 1'b1;
                            state_next  = ST_RD;
                        end
                    end
                    bstk_pkg::OP_SEARCH:
                    begin
                        if (sts.hit)
                        begin
                            cmd.emit = bstk_pkg::EM_FOUND;
                        end
                        else if (sts.idx_top)
                        begin
                            cmd.emit = bstk_pkg::EM_NOTFOUND;
                        end
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                            state_next  = ST_RD;
                        end
                    end
                    default:
                    begin
                        cmd.emit = bstk_pkg::EM_NONE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

    assign busy = (state_reg != ST_IDLE);

    `BSTK_ASSERT(a_ev_follows_rd, clk, rst_n, (state_reg == ST_EV) |-> ($past(state_reg) == ST_RD))
    `BSTK_ASSERT_NEVER(a_push_when_full, clk, rst_n, cmd.push && sts.full)

endmodule

`default_nettype wire

// ----- hdl/bstk_dpath.sv -----
// Datapath: stack memory, occupancy, scan pointer and result registers.
`default_nettype none

`include "assert_macros.svh"

module bstk_dpath
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic signed [bstk_pkg::DATA_W-1:0]   value,
    input  wire bstk_pkg::cmd_t                       cmd,
    output bstk_pkg::sts_t                            sts,
    output logic                                      strobe,
    output logic [bstk_pkg::STAT_W-1:0]               status,
    output logic signed [bstk_pkg::DATA_W-1:0]        data,
    output logic [bstk_pkg::POS_W-1:0]                position,
    output logic                                      last
);

    localparam int OW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = (OW > bstk_pkg::POS_W) ? OW : bstk_pkg::POS_W;

    logic [bstk_pkg::DATA_W-1:0]        mem [DEPTH];
    logic [bstk_pkg::DATA_W-1:0]        rd_data_reg;

    logic [OW-1:0]                      occ_reg;
    logic [OW-1:0]                      occ_next;
    logic [AW-1:0]                      idx_reg;
    logic [AW-1:0]                      idx_next;
    logic [bstk_pkg::DATA_W-1:0]        key_reg;
    logic [bstk_pkg::DATA_W-1:0]        key_next;

    logic                               strobe_reg;
    logic [bstk_pkg::STAT_W-1:0]        status_reg;
    logic [bstk_pkg::DATA_W-1:0]        data_reg;
    logic [bstk_pkg::POS_W-1:0]         position_reg;
    logic                               last_reg;

    logic [bstk_pkg::STAT_W-1:0]        em_status;
    logic [bstk_pkg::DATA_W-1:0]        em_data;
    logic [PW-1:0]                      em_pos;
    logic                               em_last;
    logic [OW-1:0]                      occ_top;
    logic                               full_beat;

    assign occ_top = occ_reg - OW'(1);

    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.push)
        begin
            occ_next = occ_reg + OW'(1);
        end
        else if (cmd.pop_commit)
        begin
            occ_next = OW'(idx_reg);
        end

        idx_next = idx_reg;
        if (cmd.idx_load_top)
        begin
            idx_next = occ_top[AW-1:0];
        end
        else if (cmd.idx_load_bottom)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - AW'(1);
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + AW'(1);
        end

        key_next = cmd.key_load ? value : key_reg;
    end

    always_comb
    begin
        em_status = bstk_pkg::STAT_OK;
        em_data   = '0;
        em_pos    = '0;
        em_last   = 1'b1;
        case (cmd.emit)
            bstk_pkg::EM_PUSH_OK:
            begin
                em_data = value;
                em_pos  = PW'(occ_reg) + PW'(1);
            end
            bstk_pkg::EM_FULL:
            begin
                em_status = bstk_pkg::STAT_FULL;
                em_pos    = PW'(occ_reg);
            end
            bstk_pkg::EM_EMPTY:
            begin
                em_status = bstk_pkg::STAT_EMPTY;
            end
            bstk_pkg::EM_POP:
            begin
                em_data = rd_data_reg;
                em_pos  = PW'(idx_reg);
            end
            bstk_pkg::EM_DUMP:
            begin
                em_data = rd_data_reg;
                em_pos  = PW'(idx_reg) + PW'(1);
                em_last = (idx_reg == '0);
            end
            bstk_pkg::EM_FOUND:
            begin
                em_data = key_reg;
                em_pos  = PW'(idx_reg) + PW'(1);
            end
            bstk_pkg::EM_NOTFOUND:
            begin
                em_status = bstk_pkg::STAT_NOTFOUND;
            end
            bstk_pkg::EM_QUERY:
            begin
                em_data = bstk_pkg::DATA_W'(DEPTH);
                em_pos  = PW'(occ_reg);
            end
            default:
            begin
                em_last = 1'b0;
            end
        endcase
    end

    // Write on push, read the scan pointer every cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[occ_reg[AW-1:0]] <= value;
        end
        rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            occ_reg    <= occ_next;
            strobe_reg <= (cmd.emit != bstk_pkg::EM_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        key_reg      <= key_next;
        status_reg   <= em_status;
        data_reg     <= em_data;
        position_reg <= em_pos[bstk_pkg::POS_W-1:0];
        last_reg     <= em_last;
    end

    assign sts.empty    = (occ_reg == '0);
    assign sts.full     = (occ_reg == OW'(DEPTH));
    assign sts.hit      = (rd_data_reg == key_reg);
    assign sts.idx_zero = (idx_reg == '0);
    assign sts.idx_top  = (OW'(idx_reg) == occ_top);

    assign strobe   = strobe_reg;
    assign status   = status_reg;
    assign data     = data_reg;
    assign position = position_reg;
    assign last     = last_reg;

    assign full_beat = strobe_reg && (status_reg == bstk_pkg::STAT_FULL);

    `BSTK_ASSERT(a_occ_bound, clk, rst_n, occ_reg <= OW'(DEPTH))
    `BSTK_ASSERT(a_full_means_depth, clk, rst_n, full_beat |-> (occ_reg == OW'(DEPTH)))

endmodule

`default_nettype wire

// ----- hdl/bounded_stack_with_search_top.sv -----
// Top level of the bounded stack with search: controller plus datapath.
`default_nettype none

// A stack of DEPTH signed 32-bit words. An operation is taken when start is
// high and busy is low. Push, query and any push on a full stack or operation
// on an empty stack give their single result in the cycle right after the
// operation is taken and keep busy low, so a new operation may follow in the
// next cycle. A pop holds busy high through a read and an evaluate state and
// gives its result after them. A dump holds busy high through these states
// once per entry and gives one beat per entry, top first, with last set on
// the bottom entry. A search does the same per entry examined, from the
// bottom, until a match or the top entry. These states come from the single
// read port of the stack memory, whose read data is registered. Each result
// beat is shown for exactly one cycle with strobe high; the receiver cannot
// hold results off and must take every beat.

module bounded_stack_with_search_top
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [bstk_pkg::OP_W-1:0]            operation,
    input  wire logic signed [bstk_pkg::DATA_W-1:0]   value,
    output logic                                      strobe,
    output logic [bstk_pkg::STAT_W-1:0]               status,
    output logic signed [bstk_pkg::DATA_W-1:0]        data,
    output logic [bstk_pkg::POS_W-1:0]                position,
    output logic                                      last
);

    bstk_pkg::cmd_t cmd;
    bstk_pkg::sts_t sts;

    bstk_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    bstk_dpath
    #(
        .DEPTH (DEPTH)
    )
    u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .value    (value),
        .cmd      (cmd),
        .sts      (sts),
        .strobe   (strobe),
        .status   (status),
        .data     (data),
        .position (position),
        .last     (last)
    );

endmodule

`default_nettype wire
